### design/spfc_pkg.sv
// Package for the SPI frame CRC fill and check block.
// Holds item and result types, the reflected CCITT byte update and constants.
// No dependencies.
package spfc_pkg;

    // Reflected CCITT polynomial, LSB first
    localparam logic [15:0] CRC_POLY      = 16'h8408;
    localparam logic [15:0] SEED_AT_RESET = 16'hA55A;

    // Master CRC skips the slot at positions 1 and 2
    localparam logic [7:0]  CRC_SLOT_END   = 8'd3;
    localparam logic [7:0]  MIN_MASTER_LEN = 8'd3;
    // Received CRC takes the last two bytes of the exchange
    localparam logic [8:0]  RX_CRC_BYTES   = 9'd2;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       first_of_frame;
        logic [7:0] master_len;
        logic [7:0] frame_len;
    } t_item;

    typedef struct packed {
        logic [15:0] master_crc;
        logic        master_crc_valid;
        logic        frame_done;
        logic        frame_ok;
        logic        length_error;
    } t_result;

    // One byte through the reflected CRC, unrolled as an XOR network
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/spfc_in_reg.sv
// Input register of the SPI frame CRC block.
// Captures one item whenever the slot is free or drains this cycle.
// Depends on spfc_pkg.
module spfc_in_reg
    import spfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    // Slot frees up when empty or when the held item moves on
    assign load    = !r_valid || i_take;
    assign o_stall = !load;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### design/spfc_core.sv
// Frame tracker of the SPI frame CRC block: position, lengths, both CRCs.
// Computes one result per item; state advances when the item is consumed.
// Depends on spfc_pkg.
module spfc_core
    import spfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [15:0] i_seed,
    input  logic        i_fire,
    input  t_item       i_item,
    output t_result     o_result
);

    logic [15:0] r_seed;
    logic [7:0]  r_position;
    logic        r_in_frame;
    logic [15:0] r_tx_crc;
    logic [15:0] r_rx_crc;
    logic [7:0]  r_got_crc_low;
    logic [7:0]  r_master_len;
    logic [7:0]  r_frame_len;

    logic [7:0]  n_position;
    logic        n_in_frame;
    logic [15:0] n_tx_crc;
    logic [15:0] n_rx_crc;
    logic [7:0]  n_got_crc_low;
    logic [7:0]  n_master_len;
    logic [7:0]  n_frame_len;

    logic        bad_len;
    logic [8:0]  p_plus1;
    logic [8:0]  p_plus2;
    logic [15:0] tx_upd;
    logic [15:0] rx_upd;
    t_result     res;

    // Seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_AT_RESET;
        end else if (i_seed_we) begin
            r_seed <= i_seed;
        end
    end

    assign bad_len = (i_item.master_len < MIN_MASTER_LEN) ||
                     ({1'b0, i_item.frame_len} < ({1'b0, i_item.master_len} + RX_CRC_BYTES));

    // Frame start, then the byte at the current position
    always_comb begin
        n_position    = r_position;
        n_in_frame    = r_in_frame;
        n_tx_crc      = r_tx_crc;
        n_rx_crc      = r_rx_crc;
        n_got_crc_low = r_got_crc_low;
        n_master_len  = r_master_len;
        n_frame_len   = r_frame_len;
        res           = '0;

        if (i_item.first_of_frame) begin
            n_master_len  = i_item.master_len;
            n_frame_len   = i_item.frame_len;
            n_position    = '0;
            n_tx_crc      = r_seed;
            n_rx_crc      = r_seed;
            n_got_crc_low = '0;
            n_in_frame    = !bad_len;
            res.length_error = bad_len;
        end else if (!r_in_frame) begin
            res.length_error = 1'b1;
        end

        p_plus1 = {1'b0, n_position} + 9'd1;
        p_plus2 = {1'b0, n_position} + RX_CRC_BYTES;
        tx_upd  = crc_byte(n_tx_crc, i_item.spi_byte);
        rx_upd  = crc_byte(n_rx_crc, i_item.spi_byte);

        if (n_in_frame) begin
            if (n_position < n_master_len) begin
                // master part, CRC slot excluded
                if (n_position == '0 || n_position >= CRC_SLOT_END) begin
                    n_tx_crc = tx_upd;
                end
                if (p_plus1 == {1'b0, n_master_len}) begin
                    res.master_crc_valid = 1'b1;
                    res.master_crc       = n_tx_crc;
                end
            end else if (p_plus2 < {1'b0, n_frame_len}) begin
                n_rx_crc = rx_upd;
            end else if (p_plus2 == {1'b0, n_frame_len}) begin
                n_got_crc_low = i_item.spi_byte;
            end else begin
                // last byte: high half of received CRC
                res.frame_done = 1'b1;
                res.frame_ok   = ({i_item.spi_byte, n_got_crc_low} == n_rx_crc);
                n_in_frame     = 1'b0;
            end
            n_position = p_plus1[7:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position    <= '0;
            r_in_frame    <= 1'b0;
            r_tx_crc      <= SEED_AT_RESET;
            r_rx_crc      <= SEED_AT_RESET;
            r_got_crc_low <= '0;
            r_master_len  <= '0;
            r_frame_len   <= '0;
        end else if (i_fire) begin
            r_position    <= n_position;
            r_in_frame    <= n_in_frame;
            r_tx_crc      <= n_tx_crc;
            r_rx_crc      <= n_rx_crc;
            r_got_crc_low <= n_got_crc_low;
            r_master_len  <= n_master_len;
            r_frame_len   <= n_frame_len;
        end
    end

    assign o_result = res;

endmodule

### design/spi_frame_crc_fill_and_check.sv
// SPI frame CRC fill and check: one result per byte, one byte per cycle while
// the output is not stalled. Each result is registered in the output register
// from the byte in the input register; the CRC byte network is combinational.
// The input register can hold one more byte while a result waits on the output.
// Reset (synchronous, active low) closes any frame and sets the seed to 0xA55A.
// Depends on spfc_pkg, spfc_in_reg, spfc_core.
module spi_frame_crc_fill_and_check
    import spfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_crc_seed_we,
    input  logic [15:0] i_crc_seed,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_spi_byte,
    input  logic        i_first_of_frame,
    input  logic [7:0]  i_master_len,
    input  logic [7:0]  i_frame_len,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_master_crc,
    output logic        o_master_crc_valid,
    output logic        o_frame_done,
    output logic        o_frame_ok,
    output logic        o_length_error
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    advance;
    logic    fire;
    t_result result;

    logic    r_out_valid;
    t_result r_out;

    assign in_item.spi_byte       = i_spi_byte;
    assign in_item.first_of_frame = i_first_of_frame;
    assign in_item.master_len     = i_master_len;
    assign in_item.frame_len      = i_frame_len;

    // Output register moves when empty or taken
    assign advance = !r_out_valid || !i_out_stall;
    assign fire    = advance && held_valid;

    spfc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_take  (advance),
        .o_stall (o_in_stall),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    spfc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed_we (i_crc_seed_we),
        .i_seed    (i_crc_seed),
        .i_fire    (fire),
        .i_item    (held_item),
        .o_result  (result)
    );

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= held_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_master_crc       = r_out.master_crc;
    assign o_master_crc_valid = r_out.master_crc_valid;
    assign o_frame_done       = r_out.frame_done;
    assign o_frame_ok         = r_out.frame_ok;
    assign o_length_error     = r_out.length_error;

endmodule

### design/spfc_checker.sv
// Port-level checks for the SPI frame CRC block, bound to the top level.
// Depends on spi_frame_crc_fill_and_check.
module spfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_master_crc,
    input logic        o_master_crc_valid,
    input logic        o_frame_done,
    input logic        o_frame_ok,
    input logic        o_length_error
);

    // Master CRC reads zero unless it is being reported
    a_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_master_crc_valid |-> o_master_crc == 16'h0000)
        else $error("master CRC nonzero without master_crc_valid");

    // A good check only comes with the frame end
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_ok |-> o_frame_done)
        else $error("frame_ok without frame_done");

    // A length error reports nothing else
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_error |->
            !o_master_crc_valid && !o_frame_done && !o_frame_ok)
        else $error("length_error together with other flags");

    // Master part always ends at least two bytes before the frame
    a_mcrc_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_master_crc_valid && o_frame_done))
        else $error("master CRC on the last byte of the frame");

    // A stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_master_crc) &&
            $stable(o_master_crc_valid) && $stable(o_frame_done) &&
            $stable(o_frame_ok) && $stable(o_length_error))
        else $error("stalled result changed");

endmodule

bind spi_frame_crc_fill_and_check spfc_checker u_spfc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_master_crc       (o_master_crc),
    .o_master_crc_valid (o_master_crc_valid),
    .o_frame_done       (o_frame_done),
    .o_frame_ok         (o_frame_ok),
    .o_length_error     (o_length_error)
);

### tb/tb.sv
// Testbench for spi_frame_crc_fill_and_check: directed and random SPI exchanges
// checked item by item against a byte-level predictor of both frame CRCs.
// Depends on spfc_pkg and the spi_frame_crc_fill_and_check RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spfc_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 850;
    localparam int SEED_PHASES  = 4;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    // DUT ports, all inputs known from time zero
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_crc_seed_we    = 1'b0;
    logic [15:0] i_crc_seed       = SEED_AT_RESET;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_spi_byte       = 8'h00;
    logic        i_first_of_frame = 1'b0;
    logic [7:0]  i_master_len     = 8'h00;
    logic [7:0]  i_frame_len      = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [15:0] o_master_crc;
    logic        o_master_crc_valid;
    logic        o_frame_done;
    logic        o_frame_ok;
    logic        o_length_error;

    // Bytes waiting to be sent and results waiting to arrive
    t_item   byte_queue[$];
    t_result frame_results[$];
    t_item   cur_item;
    int      src_gap     = 0;
    int      snk_stall   = 0;
    bit      src_quiet   = 1'b0;
    bit      snk_quiet   = 1'b0;
    int      mismatches  = 0;
    int      idle_cycles = 0;
    int      items_queued = 0;

    // Predictor state of the frame tracker
    logic [15:0] seed_cfg;
    logic [7:0]  byte_pos;
    logic        frame_open;
    logic [15:0] master_crc_run;
    logic [15:0] slave_crc_run;
    logic [7:0]  rx_crc_low;
    logic [7:0]  held_ml;
    logic [7:0]  held_fl;

    spi_frame_crc_fill_and_check i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_crc_seed_we      (i_crc_seed_we),
        .i_crc_seed         (i_crc_seed),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_spi_byte         (i_spi_byte),
        .i_first_of_frame   (i_first_of_frame),
        .i_master_len       (i_master_len),
        .i_frame_len        (i_frame_len),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_master_crc       (o_master_crc),
        .o_master_crc_valid (o_master_crc_valid),
        .o_frame_done       (o_frame_done),
        .o_frame_ok         (o_frame_ok),
        .o_length_error     (o_length_error)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Reflected CCITT, one bit at a time, LSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Advance the frame tracker by one byte and return the result it owes
    function automatic t_result predict_frame_byte(input t_item it);
        t_result r;
        int      p;
        int      ml;
        int      fl;
        r  = '0;
        ml = int'(it.master_len);
        fl = int'(it.frame_len);
        if (it.first_of_frame) begin
            held_ml        = it.master_len;
            held_fl        = it.frame_len;
            byte_pos       = 8'd0;
            master_crc_run = seed_cfg;
            slave_crc_run  = seed_cfg;
            rx_crc_low     = 8'd0;
            if (ml < MIN_MASTER_LEN || fl < ml + 2) begin
                frame_open     = 1'b0;
                r.length_error = 1'b1;
            end else begin
                frame_open = 1'b1;
            end
        end else if (!frame_open) begin
            r.length_error = 1'b1;
        end
        if (frame_open) begin
            p = int'(byte_pos);
            if (p < held_ml) begin
                // master CRC skips the slot it will fill
                if (p == 0 || p >= CRC_SLOT_END) begin
                    master_crc_run = crc_update(master_crc_run, it.spi_byte);
                end
                if (p + 1 == held_ml) begin
                    r.master_crc_valid = 1'b1;
                    r.master_crc       = master_crc_run;
                end
            end else if (p + 2 < held_fl) begin
                slave_crc_run = crc_update(slave_crc_run, it.spi_byte);
            end else if (p + 2 == held_fl) begin
                rx_crc_low = it.spi_byte;
            end else begin
                r.frame_done = 1'b1;
                r.frame_ok   = ({it.spi_byte, rx_crc_low} == slave_crc_run);
                frame_open   = 1'b0;
            end
            byte_pos = 8'(p + 1);
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none while quiet
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic push_item(input logic [7:0] b, input bit first,
                             input logic [7:0] ml, input logic [7:0] fl);
        t_item it;
        it.spi_byte       = b;
        it.first_of_frame = first;
        it.master_len     = ml;
        it.frame_len      = fl;
        byte_queue.push_back(it);
        items_queued++;
    endtask

    // One exchange cut after sent bytes; the received CRC is right when good is set
    task automatic add_frame(input int ml, input int fl, input bit good, input int sent);
        logic [15:0] c;
        logic [7:0]  b;
        logic [7:0]  flip;
        c    = seed_cfg;
        flip = good ? 8'h00 : 8'(1 << $urandom_range(0, 7));
        for (int p = 0; p < sent; p++) begin
            b = 8'($urandom_range(0, 255));
            if (p >= ml && p + 2 < fl) begin
                c = crc_update(c, b);
            end else if (p >= ml && p + 2 == fl) begin
                b = c[7:0] ^ flip;
            end else if (p >= ml) begin
                b = c[15:8];
            end
            if (p == 0) begin
                push_item(b, 1'b1, 8'(ml), 8'(fl));
            end else begin
                push_item(b, 1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Random lengths: mostly short frames, now and then a long one
    task automatic random_lengths(output int ml, output int fl);
        if ($urandom_range(0, 99) < 3) begin
            fl = $urandom_range(200, 255);
            ml = $urandom_range(3, fl - 2);
        end else begin
            ml = $urandom_range(3, 8);
            fl = ml + 2 + $urandom_range(0, 6);
        end
    endtask

    task automatic fill_random(input int count);
        int stop_at;
        int r;
        int ml;
        int fl;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
                // restart inside a frame: abandon a partial one first
                if (r >= 70) begin
                    random_lengths(ml, fl);
                    add_frame(ml, fl, 1'b1, $urandom_range(1, fl - 1));
                end
                random_lengths(ml, fl);
                add_frame(ml, fl, $urandom_range(0, 99) < 80, fl);
            end else if (r < 92) begin
                // bad lengths at frame start
                if ($urandom_range(0, 1)) begin
                    push_item(8'($urandom_range(0, 255)), 1'b1, 8'($urandom_range(0, 2)),
                              8'($urandom_range(0, 255)));
                end else begin
                    ml = $urandom_range(3, 255);
                    push_item(8'($urandom_range(0, 255)), 1'b1, 8'(ml),
                              8'($urandom_range(0, (ml + 1 > 255) ? 255 : ml + 1)));
                end
            end else begin
                // bytes with no frame open
                repeat ($urandom_range(1, 3)) begin
                    push_item(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (byte_queue.size() != 0 || i_in_valid || frame_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_seed(input logic [15:0] v);
        @(posedge i_clk);
        i_crc_seed_we <= 1'b1;
        i_crc_seed    <= v;
        @(posedge i_clk);
        i_crc_seed_we <= 1'b0;
        seed_cfg = v;
    endtask

    // Sender: one item per handshake, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                frame_results.push_back(predict_frame_byte(cur_item));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    cur_item = byte_queue.pop_front();
                    i_spi_byte       <= cur_item.spi_byte;
                    i_first_of_frame <= cur_item.first_of_frame;
                    i_master_len     <= cur_item.master_len;
                    i_frame_len      <= cur_item.frame_len;
                    i_in_valid       <= 1'b1;
                    if ($urandom_range(0, 63) == 0) begin
                        src_quiet = !src_quiet;
                    end
                    src_gap = pick_gap(src_quiet);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Receiver: check each accepted result, stall at random
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (frame_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual crc %h flags %b%b%b%b",
                             $time, o_master_crc, o_master_crc_valid, o_frame_done,
                             o_frame_ok, o_length_error);
                end else begin
                    want = frame_results.pop_front();
                    check_field("master_crc", want.master_crc, o_master_crc);
                    check_field("master_crc_valid", 16'(want.master_crc_valid),
                                16'(o_master_crc_valid));
                    check_field("frame_done", 16'(want.frame_done), 16'(o_frame_done));
                    check_field("frame_ok", 16'(want.frame_ok), 16'(o_frame_ok));
                    check_field("length_error", 16'(want.length_error),
                                16'(o_length_error));
                end
            end
            if (snk_stall > 0) begin
                snk_stall--;
                i_out_stall <= 1'b1;
            end else begin
                if ($urandom_range(0, 63) == 0) begin
                    snk_quiet = !snk_quiet;
                end
                snk_stall = pick_gap(snk_quiet);
                if (snk_stall > 0) begin
                    snk_stall--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || i_crc_seed_we || (i_in_valid && !o_in_stall)
            || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [15:0] phase_seed;
        seed_cfg       = SEED_AT_RESET;
        byte_pos       = 8'd0;
        frame_open     = 1'b0;
        master_crc_run = SEED_AT_RESET;
        slave_crc_run  = SEED_AT_RESET;
        rx_crc_low     = 8'd0;
        held_ml        = 8'd0;
        held_fl        = 8'd0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed exchanges at the reset seed
        @(negedge i_clk);
        push_item(8'hFF, 1'b0, 8'h00, 8'h00);   // byte with no frame open
        push_item(8'h00, 1'b1, 8'd0, 8'd255);   // master part too short
        push_item(8'hFF, 1'b1, 8'd2, 8'd255);
        push_item(8'h55, 1'b1, 8'd255, 8'd255); // no room for the received CRC
        push_item(8'hAA, 1'b1, 8'd3, 8'd4);
        add_frame(3, 5, 1'b1, 5);               // empty slave payload
        add_frame(4, 8, 1'b1, 3);               // abandoned by the next start
        add_frame(3, 5, 1'b0, 5);
        add_frame(3, 6, 1'b1, 6);
        push_item(8'h00, 1'b1 ^ 1'b1, 8'hFF, 8'hFF);
        wait_drained();

        // Random exchanges under several seeds, extremes first
        for (int ph = 0; ph < SEED_PHASES; ph++) begin
            case (ph)
                0: begin
                    phase_seed = 16'h0000;
                end
                1: begin
                    phase_seed = 16'hFFFF;
                end
                default: begin
                    phase_seed = 16'($urandom_range(0, 65535));
                end
            endcase
            write_seed(phase_seed);
            @(negedge i_clk);
            fill_random(RANDOM_ITEMS / SEED_PHASES);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### spi_frame_crc_fill_and_check.f
design/spfc_pkg.sv
design/spfc_in_reg.sv
design/spfc_core.sv
design/spi_frame_crc_fill_and_check.sv
design/spfc_checker.sv
tb/tb.sv
